@@ design/bfsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bfsa_pkg;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast command to all cells
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SNAP,
    CMD_RESTORE,
    CMD_APPLY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LAUNCH,
    FSM_SCAN,
    FSM_OUT
  } fsm_t;

  typedef enum logic [1:0] {
    PH_ALLOC,
    PH_LEAD,
    PH_TRAIL,
    PH_FREE
  } phase_t;

endpackage
`default_nettype wire

@@ design/best_fit_segment_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata | tuser | content
// in_     | in  | 80    | 1     | request beat: heap_id, seg_offset, seg_size, align_log2; tuser opcode
// out_    | out | 48    | -     | result beat: status, grant_heap, grant_offset
//
// the free table is a chain of TABLE_ENTRIES cells; a token walks the chain one
// cell per cycle, and a scan runs from launch until the token leaves the last cell
// free: one scan per beat, none for an empty free; allocate: up to three scans
// (best fit, leading remainder, trailing remainder); results wait for out_tready
// synchronous active-low reset empties the table at once
// one request at a time: in_tready is low from acceptance until its result beat
// has been taken on the out_ side
module best_fit_segment_allocator_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int OFFSET_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,   // heap_id[8], seg_offset[32], seg_size[32], align_log2[5]
  input  wire         in_tuser,   // opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // status[2], grant_heap[8], grant_offset[32]
);

  localparam int LW = OFFSET_BITS + 1;
  localparam int W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int OM = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [W-1:0] SPACE = W'(1) << OFFSET_BITS;

  typedef struct packed {
    logic                   vld;
    logic                   is_alloc;
    logic [7:0]             heap;
    logic [W-1:0]           beg;
    logic [W-1:0]           fin;
    logic [W-1:0]           amask;
    logic [W-1:0]           size;
    logic                   best_hit;
    logic [IW-1:0]          best_idx;
    logic [LW-1:0]          best_len;
    logic [7:0]             best_heap;
    logic [OFFSET_BITS-1:0] best_start;
    logic [W-1:0]           best_al;
    logic                   aft_hit;
    logic [IW-1:0]          aft_idx;
    logic [LW-1:0]          aft_len;
    logic                   bef_hit;
    logic [IW-1:0]          bef_idx;
    logic [OFFSET_BITS-1:0] bef_start;
    logic                   emp_hit;
    logic [IW-1:0]          emp_idx;
  } tok_t;

  typedef struct packed {
    bfsa_pkg::cmd_kind_t    kind;
    logic                   wr_en;
    logic [IW-1:0]          wr_idx;
    logic [7:0]             heap;
    logic [OFFSET_BITS-1:0] start;
    logic [LW-1:0]          len;
    logic                   ia_en;
    logic [IW-1:0]          ia_idx;
    logic                   ib_en;
    logic [IW-1:0]          ib_idx;
  } cmd_t;

  tok_t chain [TABLE_ENTRIES+1];
  tok_t tail;
  cmd_t cmd;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      bfsa_cell #(
        .OFFSET_BITS(OFFSET_BITS),
        .IDX_W(IW),
        .IDX(IW'(g)),
        .tok_t(tok_t),
        .cmd_t(cmd_t)
      ) u_cell (
        .clk(clk),
        .rst_n(rst_n),
        .tok_in(chain[g]),
        .tok_out(chain[g+1]),
        .cmd(cmd)
      );
    end
  endgenerate

  assign tail = chain[TABLE_ENTRIES];

  // controller state
  bfsa_pkg::fsm_t   state_r, state_nxt;
  bfsa_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       heap_r, heap_nxt;
  logic [W-1:0]     beg_r, beg_nxt, fin_r, fin_nxt;
  logic [W-1:0]     amask_r, amask_nxt, size_r, size_nxt;
  logic [W-1:0]     bal_r, bal_nxt, bend_r, bend_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       gheap_r, gheap_nxt;
  logic [31:0]      goff_r, goff_nxt;
  logic             ovalid_r, ovalid_nxt;

  // input fields
  logic          f_op;
  logic [7:0]    f_heap;
  logic [31:0]   f_off, f_size;
  logic [4:0]    f_lg;
  logic [W-1:0]  in_beg, in_fin, in_amask;

  // commit helpers
  logic          any_slot;
  logic [IW-1:0] slot;
  logic [W-1:0]  new_beg, new_fin, req_end;
  logic          accept;

  assign f_op   = in_tuser;
  assign f_heap = in_tdata[7:0];
  assign f_off  = in_tdata[39:8];
  assign f_size = in_tdata[71:40];
  assign f_lg   = in_tdata[76:72];
  assign accept = in_tvalid && in_tready;

  assign in_tready  = (state_r == bfsa_pkg::FSM_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, goff_r, gheap_r, status_r};

  always_comb begin
    // free request trimmed to the address space
    in_beg   = W'(f_off[OM-1:0]);
    in_fin   = in_beg + W'(f_size);
    if (in_fin > SPACE) begin
      in_fin = SPACE;
    end
    in_amask = (W'(1) << f_lg) - W'(1);

    // lowest free slot once neighbours are merged away
    any_slot = tail.emp_hit || tail.aft_hit || tail.bef_hit;
    slot     = tail.emp_idx;
    if (!tail.emp_hit || (tail.aft_hit && tail.aft_idx < slot)) begin
      if (tail.aft_hit) begin
        slot = tail.aft_idx;
      end
    end
    if (tail.bef_hit && (!(tail.emp_hit || tail.aft_hit) || tail.bef_idx < slot)) begin
      slot = tail.bef_idx;
    end
    new_beg = tail.bef_hit ? W'(tail.bef_start) : beg_r;
    new_fin = tail.aft_hit ? (fin_r + W'(tail.aft_len)) : fin_r;
    req_end = bal_r + size_r;

    state_nxt  = state_r;
    phase_nxt  = phase_r;
    heap_nxt   = heap_r;
    beg_nxt    = beg_r;
    fin_nxt    = fin_r;
    amask_nxt  = amask_r;
    size_nxt   = size_r;
    bal_nxt    = bal_r;
    bend_nxt   = bend_r;
    status_nxt = status_r;
    gheap_nxt  = gheap_r;
    goff_nxt   = goff_r;
    ovalid_nxt = ovalid_r;

    chain[0]          = '0;
    chain[0].is_alloc = (phase_r == bfsa_pkg::PH_ALLOC);
    chain[0].heap     = heap_r;
    chain[0].beg      = beg_r;
    chain[0].fin      = fin_r;
    chain[0].amask    = amask_r;
    chain[0].size     = size_r;

    cmd        = '0;
    cmd.kind   = bfsa_pkg::CMD_NONE;
    cmd.heap   = heap_r;
    cmd.start  = new_beg[OFFSET_BITS-1:0];
    cmd.len    = LW'(new_fin - new_beg);
    cmd.wr_idx = slot;
    cmd.ia_idx = tail.aft_idx;
    cmd.ib_idx = tail.bef_idx;

    case (state_r)
      bfsa_pkg::FSM_IDLE: begin
        if (accept) begin
          cmd.kind   = bfsa_pkg::CMD_SNAP;
          heap_nxt   = f_heap;
          amask_nxt  = in_amask;
          size_nxt   = W'(f_size);
          status_nxt = bfsa_pkg::ST_DONE;
          gheap_nxt  = '0;
          goff_nxt   = '0;
          if (f_op == bfsa_pkg::OP_FREE) begin
            beg_nxt   = in_beg;
            fin_nxt   = in_fin;
            phase_nxt = bfsa_pkg::PH_FREE;
            if (in_beg >= in_fin) begin
              ovalid_nxt = 1'b1;
              state_nxt  = bfsa_pkg::FSM_OUT;
            end else begin
              state_nxt = bfsa_pkg::FSM_LAUNCH;
            end
          end else begin
            phase_nxt = bfsa_pkg::PH_ALLOC;
            state_nxt = bfsa_pkg::FSM_LAUNCH;
          end
        end
      end
      bfsa_pkg::FSM_LAUNCH: begin
        chain[0].vld = 1'b1;
        state_nxt    = bfsa_pkg::FSM_SCAN;
      end
      bfsa_pkg::FSM_SCAN: begin
        if (tail.vld) begin
          case (phase_r)
            bfsa_pkg::PH_ALLOC: begin
              if (!tail.best_hit) begin
                status_nxt = bfsa_pkg::ST_NOFIT;
                ovalid_nxt = 1'b1;
                state_nxt  = bfsa_pkg::FSM_OUT;
              end else begin
                // take the winner out of the table
                cmd.kind   = bfsa_pkg::CMD_APPLY;
                cmd.ia_en  = 1'b1;
                cmd.ia_idx = tail.best_idx;
                heap_nxt   = tail.best_heap;
                bal_nxt    = tail.best_al;
                bend_nxt   = W'(tail.best_start) + W'(tail.best_len);
                gheap_nxt  = tail.best_heap;
                goff_nxt   = tail.best_al[31:0];
                if (tail.best_al > W'(tail.best_start)) begin
                  beg_nxt   = W'(tail.best_start);
                  fin_nxt   = tail.best_al;
                  phase_nxt = bfsa_pkg::PH_LEAD;
                  state_nxt = bfsa_pkg::FSM_LAUNCH;
                end else if ((tail.best_al + size_r) <
                             (W'(tail.best_start) + W'(tail.best_len))) begin
                  beg_nxt   = tail.best_al + size_r;
                  fin_nxt   = W'(tail.best_start) + W'(tail.best_len);
                  phase_nxt = bfsa_pkg::PH_TRAIL;
                  state_nxt = bfsa_pkg::FSM_LAUNCH;
                end else begin
                  ovalid_nxt = 1'b1;
                  state_nxt  = bfsa_pkg::FSM_OUT;
                end
              end
            end
            bfsa_pkg::PH_LEAD: begin
              // the winner's slot is free, so this always finds room
              cmd.kind  = bfsa_pkg::CMD_APPLY;
              cmd.wr_en = 1'b1;
              cmd.ia_en = tail.aft_hit;
              cmd.ib_en = tail.bef_hit;
              if (req_end < bend_r) begin
                beg_nxt   = req_end;
                fin_nxt   = bend_r;
                phase_nxt = bfsa_pkg::PH_TRAIL;
                state_nxt = bfsa_pkg::FSM_LAUNCH;
              end else begin
                ovalid_nxt = 1'b1;
                state_nxt  = bfsa_pkg::FSM_OUT;
              end
            end
            default: begin
              // trailing remainder or plain free
              ovalid_nxt = 1'b1;
              state_nxt  = bfsa_pkg::FSM_OUT;
              if (any_slot) begin
                cmd.kind  = bfsa_pkg::CMD_APPLY;
                cmd.wr_en = 1'b1;
                cmd.ia_en = tail.aft_hit;
                cmd.ib_en = tail.bef_hit;
              end else begin
                if (phase_r == bfsa_pkg::PH_TRAIL) begin
                  cmd.kind = bfsa_pkg::CMD_RESTORE;
                end
                status_nxt = bfsa_pkg::ST_FULL;
                gheap_nxt  = '0;
                goff_nxt   = '0;
              end
            end
          endcase
        end
      end
      bfsa_pkg::FSM_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = bfsa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = bfsa_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bfsa_pkg::FSM_IDLE;
      phase_r  <= bfsa_pkg::PH_ALLOC;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    heap_r   <= heap_nxt;
    beg_r    <= beg_nxt;
    fin_r    <= fin_nxt;
    amask_r  <= amask_nxt;
    size_r   <= size_nxt;
    bal_r    <= bal_nxt;
    bend_r   <= bend_nxt;
    status_r <= status_nxt;
    gheap_r  <= gheap_nxt;
    goff_r   <= goff_nxt;
  end

  // a new request never lands while a result is still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !out_tvalid) else $error("request accepted with result pending");

  // failed requests carry no grant
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != bfsa_pkg::ST_DONE) |-> (out_tdata[41:2] == '0))
    else $error("grant on failed request");

  // the chain only carries a token during a scan
  a_tail_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == bfsa_pkg::FSM_SCAN)) else $error("stray scan token");

  // a launch is always followed by a scan
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfsa_pkg::FSM_LAUNCH) |=> (state_r == bfsa_pkg::FSM_SCAN))
    else $error("launch not followed by scan");

endmodule
`default_nettype wire

@@ design/bfsa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bfsa_cell #(
  parameter int OFFSET_BITS = 32,
  parameter int IDX_W = 6,
  parameter logic [IDX_W-1:0] IDX = '0,
  parameter type tok_t = logic,
  parameter type cmd_t = logic
) (
  input  wire  clk,
  input  wire  rst_n,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  cmd_t cmd
);

  localparam int LW = OFFSET_BITS + 1;
  localparam int W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
  localparam logic [W-1:0] CAP = (OFFSET_BITS < 32) ? (W'(1) << OFFSET_BITS)
                                                   : (W'(1) << 32);

  logic                   valid_r, sh_valid_r;
  logic [7:0]             heap_r, sh_heap_r;
  logic [OFFSET_BITS-1:0] start_r, sh_start_r;
  logic [LW-1:0]          len_r, sh_len_r;
  tok_t                   tok_r, tok_nxt;

  logic [W-1:0] s_w, e_w, al_w;
  logic         fits, better, hit_me, inval_me;

  always_comb begin
    s_w  = W'(start_r);
    e_w  = s_w + W'(len_r);
    al_w = (s_w + tok_in.amask) & ~tok_in.amask;
    fits = (al_w < CAP) && ((al_w + tok_in.size) <= e_w);
    better = !tok_in.best_hit || (len_r < tok_in.best_len) ||
             ((len_r == tok_in.best_len) && ((heap_r < tok_in.best_heap) ||
              ((heap_r == tok_in.best_heap) && (start_r < tok_in.best_start))));
    tok_nxt = tok_in;
    if (tok_in.vld && valid_r) begin
      if (tok_in.is_alloc) begin
        if (fits && better) begin
          tok_nxt.best_hit   = 1'b1;
          tok_nxt.best_idx   = IDX;
          tok_nxt.best_len   = len_r;
          tok_nxt.best_heap  = heap_r;
          tok_nxt.best_start = start_r;
          tok_nxt.best_al    = al_w;
        end
      end else if (heap_r == tok_in.heap) begin
        if (!tok_in.aft_hit && (s_w == tok_in.fin)) begin
          tok_nxt.aft_hit = 1'b1;
          tok_nxt.aft_idx = IDX;
          tok_nxt.aft_len = len_r;
        end
        if (!tok_in.bef_hit && (e_w == tok_in.beg)) begin
          tok_nxt.bef_hit   = 1'b1;
          tok_nxt.bef_idx   = IDX;
          tok_nxt.bef_start = start_r;
        end
      end
    end
    if (tok_in.vld && !valid_r && !tok_in.emp_hit) begin
      tok_nxt.emp_hit = 1'b1;
      tok_nxt.emp_idx = IDX;
    end
    hit_me   = cmd.wr_en && (cmd.wr_idx == IDX);
    inval_me = (cmd.ia_en && (cmd.ia_idx == IDX)) || (cmd.ib_en && (cmd.ib_idx == IDX));
  end

  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      valid_r    <= 1'b0;
      sh_valid_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      case (cmd.kind)
        bfsa_pkg::CMD_SNAP: begin
          sh_valid_r <= valid_r;
          sh_heap_r  <= heap_r;
          sh_start_r <= start_r;
          sh_len_r   <= len_r;
        end
        bfsa_pkg::CMD_RESTORE: begin
          valid_r <= sh_valid_r;
          heap_r  <= sh_heap_r;
          start_r <= sh_start_r;
          len_r   <= sh_len_r;
        end
        bfsa_pkg::CMD_APPLY: begin
          if (hit_me) begin
            valid_r <= 1'b1;
            heap_r  <= cmd.heap;
            start_r <= cmd.start;
            len_r   <= cmd.len;
          end else if (inval_me) begin
            valid_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/best_fit_segment_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module best_fit_segment_allocator_unit_tb;

  localparam int ENTRIES = 64;
  localparam int OFFB = 32;
  localparam longint unsigned SPACE = 64'd1 << OFFB;
  localparam longint unsigned CAP = 64'd1 << 32;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [4:0]  align_log2;
    logic [31:0] seg_size;
    logic [31:0] seg_offset;
    logic [7:0]  heap_id;
    logic        opcode;
  } req_t;

  typedef struct packed {
    logic [31:0] grant_offset;
    logic [7:0]  grant_heap;
    logic [1:0]  status;
  } grant_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [79:0] in_tdata;   // heap_id, seg_offset, seg_size, align_log2, zero pad
  logic in_tuser;          // opcode
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;  // status, grant_heap, grant_offset

  best_fit_segment_allocator_unit #(
    .TABLE_ENTRIES(ENTRIES),
    .OFFSET_BITS(OFFB)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor copy of the free table
  bit              fl_valid [ENTRIES];
  logic [7:0]      fl_heap  [ENTRIES];
  longint unsigned fl_start [ENTRIES];
  longint unsigned fl_len   [ENTRIES];

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     mismatches;
  int     beats_in, beats_out;
  int     n_full, n_nofit, n_done;
  longint cycle_count;
  bit     stim_done;
  bit     hold_sender;   // sender waits for the result queue to drain
  int     long_stall;    // receiver hold-off counter

  // insert a free segment with coalescing; 0 means no slot left
  function automatic bit return_segment(logic [7:0] h, longint unsigned b,
                                        longint unsigned len);
    longint unsigned e;
    int nxt, prv, slot;
    e = b + len;
    nxt = -1; prv = -1; slot = -1;
    if (e > SPACE) e = SPACE;
    if (b >= e) return 1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (fl_valid[i] && fl_heap[i] == h) begin
        if (nxt < 0 && fl_start[i] == e) nxt = i;
        if (prv < 0 && fl_start[i] + fl_len[i] == b) prv = i;
      end
    end
    if (nxt >= 0) begin
      e += fl_len[nxt];
      fl_valid[nxt] = 0;
    end
    if (prv >= 0 && prv != nxt) begin
      b = fl_start[prv];
      fl_valid[prv] = 0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!fl_valid[i]) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) return 0;
    fl_valid[slot] = 1;
    fl_heap[slot] = h;
    fl_start[slot] = b;
    fl_len[slot] = e - b;
    return 1;
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    bit              sv_valid [ENTRIES];
    logic [7:0]      sv_heap  [ENTRIES];
    longint unsigned sv_start [ENTRIES];
    longint unsigned sv_len   [ENTRIES];
    longint unsigned amask, s, e, al, best_al, req_end;
    int best;
    bit ok;
    g = '0;
    sv_valid = fl_valid; sv_heap = fl_heap; sv_start = fl_start; sv_len = fl_len;
    if (r.opcode == bfsa_pkg::OP_FREE) begin
      if (!return_segment(r.heap_id, longint'(r.seg_offset) & (SPACE - 1),
                          longint'(r.seg_size))) begin
        g.status = bfsa_pkg::ST_FULL;
      end else begin
        g.status = bfsa_pkg::ST_DONE;
      end
    end else begin
      amask = (64'd1 << r.align_log2) - 1;
      best = -1;
      best_al = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!fl_valid[i]) continue;
        s = fl_start[i];
        e = s + fl_len[i];
        al = (s + amask) & ~amask;
        if (al >= CAP || al >= SPACE || al + r.seg_size > e) continue;
        if (best < 0 || fl_len[i] < fl_len[best] ||
            (fl_len[i] == fl_len[best] && (fl_heap[i] < fl_heap[best] ||
             (fl_heap[i] == fl_heap[best] && s < fl_start[best])))) begin
          best = i;
          best_al = al;
        end
      end
      if (best < 0) begin
        g.status = bfsa_pkg::ST_NOFIT;
      end else begin
        s = fl_start[best];
        e = s + fl_len[best];
        req_end = best_al + r.seg_size;
        ok = 1;
        fl_valid[best] = 0;
        if (best_al > s) ok = return_segment(fl_heap[best], s, best_al - s);
        if (ok && req_end < e) ok = return_segment(fl_heap[best], req_end, e - req_end);
        if (!ok) begin
          g.status = bfsa_pkg::ST_FULL;
        end else begin
          g.status = bfsa_pkg::ST_DONE;
          g.grant_heap = fl_heap[best];
          g.grant_offset = best_al[31:0];
        end
      end
    end
    // table full leaves the table untouched
    if (g.status == bfsa_pkg::ST_FULL) begin
      fl_valid = sv_valid; fl_heap = sv_heap; fl_start = sv_start; fl_len = sv_len;
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("beat %0d: %s got 0x%0h want 0x%0h", beats_out, what, got, want);
    mismatches++;
  endtask

  function automatic req_t make_req(bit op, logic [7:0] h, logic [31:0] off,
                                    logic [31:0] sz, logic [4:0] lg);
    req_t r;
    r.opcode = op; r.heap_id = h; r.seg_offset = off; r.seg_size = sz; r.align_log2 = lg;
    return r;
  endfunction

  // sizes mostly small, sometimes anything
  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // stimulus list: directed then random
  initial begin
    logic [31:0] base;
    for (int i = 0; i < ENTRIES; i++) begin
      fl_valid[i] = 0; fl_heap[i] = '0; fl_start[i] = 0; fl_len[i] = 0;
    end
    // directed: empty table, extremes, trimming, merges, zero size, alignment
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'hff, 32'hffffffff, 32'd0, 5'd31));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd3, 32'd100, 32'd0, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'hff, 32'hffffff00, 32'hffffffff,
                                    5'd31));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd0, 32'd0, 32'd100, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd0, 32'd200, 32'd50, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd0, 32'd100, 32'd100, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd1, 32'd0, 32'd250, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd0, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd10, 5'd4));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd200, 5'd6));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd1, 5'd31));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'hffffffff, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'h80, 5'd31));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd0, 32'd10, 32'd5, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd0, 32'd10, 32'd5, 5'd0));
    // fill the table with isolated segments to reach table full
    for (int i = 0; i < ENTRIES + 4; i++)
      pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE, 8'd7, 32'h10000 + i * 16, 32'd8,
                                      5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd2, 5'd0));
    pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'd0, 32'd0, 32'd1, 5'd2));
    // random: frees mostly at low offsets in heaps 0 to 3, and allocations
    for (int i = 0; i < 2000; i++) begin
      base = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4095);
      if ($urandom_range(0, 1))
        pending_reqs.push_back(make_req(bfsa_pkg::OP_FREE,
                               $urandom_range(0, 9) == 0 ? 8'($urandom()) :
                               8'($urandom_range(0, 3)), base, rand_size(), 5'($urandom())));
      else
        pending_reqs.push_back(make_req(bfsa_pkg::OP_ALLOC, 8'($urandom()), $urandom(),
                               rand_size(), $urandom_range(0, 5) == 0 ? 5'($urandom()) :
                               5'($urandom_range(0, 4))));
    end
  end

  // driver: bursts with gaps, one pause until everything has come back
  int burst_left, gap_left;
  always @(posedge clk) begin
    req_t nreq;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tuser <= 0;
      burst_left <= 0; gap_left <= 0; stim_done <= 0; hold_sender <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_grants.push_back(predict_grant(make_req(in_tuser, in_tdata[7:0],
                                  in_tdata[39:8], in_tdata[71:40], in_tdata[76:72])));
        beats_in++;
        if (beats_in == 600) hold_sender <= 1;
      end
      if (hold_sender && expected_grants.size() == 0 && !(in_tvalid && in_tready))
        hold_sender <= 0;
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() == 0) begin
          in_tvalid <= 0;
          stim_done <= 1;
        end else if (hold_sender || beats_in == 600 && in_tvalid && in_tready) begin
          in_tvalid <= 0;
        end else if (gap_left > 0) begin
          in_tvalid <= 0;
          gap_left <= gap_left - 1;
        end else begin
          nreq = pending_reqs.pop_front();
          in_tvalid <= 1;
          in_tuser <= nreq.opcode;
          in_tdata <= {3'b0, nreq.align_log2, nreq.seg_size, nreq.seg_offset, nreq.heap_id};
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // monitor: stall pattern plus one long hold-off, compare fields
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst_n) begin
      out_tready <= 0;
      long_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        beats_out++;
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result beat", got, 0);
        end else begin
          want = expected_grants.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.grant_heap != want.grant_heap)
            report_mismatch("grant_heap", got.grant_heap, want.grant_heap);
          if (got.grant_offset != want.grant_offset)
            report_mismatch("grant_offset", got.grant_offset, want.grant_offset);
          case (want.status)
            bfsa_pkg::ST_DONE: n_done++;
            bfsa_pkg::ST_NOFIT: n_nofit++;
            default: n_full++;
          endcase
        end
      end
      if (beats_out == 300 && long_stall == 0) long_stall <= 3000;
      if (long_stall > 1) begin
        long_stall <= long_stall - 1;
        out_tready <= 0;
      end else begin
        if (long_stall == 1) long_stall <= -1;
        out_tready <= (cycle_count % 97) < 40 ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0; out_tready = 0;
    mismatches = 0; beats_in = 0; beats_out = 0;
    n_done = 0; n_nofit = 0; n_full = 0; cycle_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && expected_grants.size() == 0);
    repeat (3 * ENTRIES + 20) @(posedge clk);
    $display("%0d request beats, %0d result beats", beats_in, beats_out);
    $display("done %0d, no fit %0d, table full %0d", n_done, n_nofit, n_full);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
`default_nettype wire

@@ filelist.f @@
design/bfsa_pkg.sv
design/bfsa_cell.sv
design/best_fit_segment_allocator_unit.sv
tb/sv/best_fit_segment_allocator_unit_tb.sv
